// ===== rtl/bsu_pkg.sv =====
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared types and constants for the byte order mark sniffing UTF-16/UTF-32
// to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package bsu_pkg;

    // detected encoding, undecided while the mark is still being sniffed
    typedef enum logic [2:0] {
        ENC_UTF8      = 3'd0,
        ENC_UTF16LE   = 3'd1,
        ENC_UTF16BE   = 3'd2,
        ENC_UTF32LE   = 3'd3,
        ENC_UTF32BE   = 3'd4,
        ENC_UNDECIDED = 3'd7
    } enc_t;

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_RAW  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  result_kind;
        logic [2:0]  detected_encoding;
        logic        last_result;
    } out_item_t;

    // most results one input byte can cause
    localparam int MAX_RESULTS = 4;

    // results of one transaction, decoder to queue
    typedef struct packed {
        logic [2:0]                        count;
        out_item_t [0:MAX_RESULTS-1]       item;
    } res_bundle_t;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;

    // byte order marks, padded to four bytes
    localparam logic [0:3][7:0] BOM_UTF8    = {8'hEF, 8'hBB, 8'hBF, 8'h00};
    localparam logic [0:3][7:0] BOM_UTF32LE = {8'hFF, 8'hFE, 8'h00, 8'h00};
    localparam logic [0:3][7:0] BOM_UTF32BE = {8'h00, 8'h00, 8'hFE, 8'hFF};
    localparam logic [0:3][7:0] BOM_UTF16LE = {8'hFF, 8'hFE, 8'h00, 8'h00};
    localparam logic [0:3][7:0] BOM_UTF16BE = {8'hFE, 8'hFF, 8'h00, 8'h00};

    localparam logic [2:0] BOM_UTF8_LEN  = 3'd3;
    localparam logic [2:0] BOM_UTF32_LEN = 3'd4;
    localparam logic [2:0] BOM_UTF16_LEN = 3'd2;

    // surrogates and scalar limits
    localparam logic [5:0]  HI_SURR_PREFIX = 6'b110110;
    localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;
    localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
    localparam logic [31:0] SURR_MIN       = 32'h0000_D800;
    localparam logic [31:0] SURR_MAX       = 32'h0000_DFFF;
    localparam logic [31:0] SCALAR_MAX     = 32'h0010_FFFF;
    localparam logic [20:0] PLANE1_BASE    = 21'h01_0000;

endpackage

// ===== rtl/bsu_decode.sv =====
// ----------------------------------------------------------------------------
// bsu_decode
// Stream state and per-byte decode: mark sniffing, unit gathering, surrogate
// checks and end-of-stream flush. Produces up to four results per byte.
// ----------------------------------------------------------------------------
module bsu_decode
    import bsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  in_item_t    item,
    output res_bundle_t bundle
);

    logic [0:2][7:0] sniff_reg, sniff_next;
    logic [1:0]      sniff_count_reg, sniff_count_next;
    enc_t            mode_reg, mode_next;
    logic [23:0]     gather_reg, gather_next;
    logic [1:0]      phase_reg, phase_next;
    logic [9:0]      surr_reg, surr_next;
    logic            held_reg, held_next;

    logic [7:0]      b;
    logic            fin;
    logic [2:0]      n;
    logic [0:3][7:0] seen;
    logic            u8_ok, u32le_ok, u32be_ok, u16le_ok, u16be_ok;
    logic            u8_full, u32le_full, u32be_full, u16le_full, u16be_full;
    logic            any_pre;
    enc_t            dec_mode;
    logic            keep;
    logic            feed_b;
    logic [1:0]      raw_n;
    logic [1:0]      nx_phase;
    logic [23:0]     nx_gather;
    logic [9:0]      nx_surr;
    logic            nx_held;
    logic            unit_go;
    logic [15:0]     unit16;
    logic            is_hi, is_lo, pair_done;
    logic            scalar_go;
    logic [31:0]     scalar;
    logic            scalar_bad;
    logic [20:0]     scalar_off;
    logic [2:0]      cnt;

    function automatic logic mark_ok(
        input logic [0:3][7:0] bytes_seen,
        input logic [2:0]      seen_n,
        input logic [0:3][7:0] mark,
        input logic [2:0]      mark_len
    );
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < mark_len && 3'(i) < seen_n && bytes_seen[i] != mark[i])
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic out_item_t make_item(
        input logic [15:0] unit,
        input kind_t       kind,
        input enc_t        enc
    );
        out_item_t it;
        it.code_unit         = unit;
        it.result_kind       = kind;
        it.detected_encoding = enc;
        it.last_result       = 1'b0;
        return it;
    endfunction

    // sniff window and mark matching
    always_comb
    begin
        b    = item.data_byte;
        fin  = item.end_of_stream;
        n    = {1'b0, sniff_count_reg} + 3'd1;
        seen = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < sniff_count_reg)
                seen[i] = sniff_reg[i];
        end
        seen[sniff_count_reg] = b;

        u8_ok    = mark_ok(seen, n, BOM_UTF8, BOM_UTF8_LEN);
        u32le_ok = mark_ok(seen, n, BOM_UTF32LE, BOM_UTF32_LEN);
        u32be_ok = mark_ok(seen, n, BOM_UTF32BE, BOM_UTF32_LEN);
        u16le_ok = mark_ok(seen, n, BOM_UTF16LE, BOM_UTF16_LEN);
        u16be_ok = mark_ok(seen, n, BOM_UTF16BE, BOM_UTF16_LEN);

        u8_full    = u8_ok && n >= BOM_UTF8_LEN;
        u32le_full = u32le_ok && n >= BOM_UTF32_LEN;
        u32be_full = u32be_ok && n >= BOM_UTF32_LEN;
        u16le_full = u16le_ok && n >= BOM_UTF16_LEN;
        u16be_full = u16be_ok && n >= BOM_UTF16_LEN;

        any_pre = (u8_ok && n < BOM_UTF8_LEN) || (u32le_ok && n < BOM_UTF32_LEN)
                || (u32be_ok && n < BOM_UTF32_LEN) || (u16le_ok && n < BOM_UTF16_LEN)
                || (u16be_ok && n < BOM_UTF16_LEN);
    end

    // decision and the state the current byte is fed into
    always_comb
    begin
        dec_mode  = mode_reg;
        keep      = 1'b0;
        feed_b    = 1'b1;
        raw_n     = 2'd0;
        nx_phase  = phase_reg;
        nx_gather = gather_reg;
        nx_surr   = surr_reg;
        nx_held   = held_reg;
        if (mode_reg == ENC_UNDECIDED)
        begin
            // state other than the sniff window is at reset while undecided
            nx_phase  = 2'd0;
            nx_gather = '0;
            nx_surr   = '0;
            nx_held   = 1'b0;
            if (u8_full)
            begin
                dec_mode = ENC_UTF8;
                feed_b   = 1'b0;
            end
            else if (u32le_full)
            begin
                dec_mode = ENC_UTF32LE;
                feed_b   = 1'b0;
            end
            else if (u32be_full)
            begin
                dec_mode = ENC_UTF32BE;
                feed_b   = 1'b0;
            end
            else if (!fin && any_pre)
            begin
                dec_mode = ENC_UNDECIDED;
                keep     = 1'b1;
                feed_b   = 1'b0;
            end
            else if (u16le_full || u16be_full)
            begin
                dec_mode = u16le_full ? ENC_UTF16LE : ENC_UTF16BE;
                // bytes after the mark: none, only this one, or a held one plus this
                feed_b   = (n != 3'd2);
                if (n == 3'd4)
                begin
                    nx_phase  = 2'd1;
                    nx_gather = {16'd0, sniff_reg[2]};
                end
            end
            else
            begin
                // no mark: held bytes go out raw, then this byte
                dec_mode = ENC_UTF8;
                raw_n    = sniff_count_reg;
            end
        end

        // feed, emit and end-of-stream flush
        bundle    = '0;
        cnt       = 3'd0;
        unit_go   = 1'b0;
        unit16    = '0;
        scalar_go = 1'b0;
        scalar    = '0;
        pair_done = 1'b0;

        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < raw_n)
            begin
                bundle.item[cnt[1:0]] = make_item({8'd0, sniff_reg[i]}, KIND_RAW, dec_mode);
                cnt = cnt + 3'd1;
            end
        end

        if (feed_b)
        begin
            case (dec_mode)
                ENC_UTF16LE, ENC_UTF16BE:
                begin
                    if (nx_phase == 2'd0)
                    begin
                        nx_gather = {16'd0, b};
                        nx_phase  = 2'd1;
                    end
                    else
                    begin
                        unit16    = (dec_mode == ENC_UTF16LE) ? {b, nx_gather[7:0]}
                                                              : {nx_gather[7:0], b};
                        unit_go   = 1'b1;
                        nx_gather = '0;
                        nx_phase  = 2'd0;
                    end
                end
                ENC_UTF32LE, ENC_UTF32BE:
                begin
                    if (nx_phase != 2'd3)
                    begin
                        if (dec_mode == ENC_UTF32LE)
                            nx_gather = nx_gather | ({16'd0, b} << {nx_phase, 3'b000});
                        else
                            nx_gather = {nx_gather[15:0], b};
                        nx_phase = nx_phase + 2'd1;
                    end
                    else
                    begin
                        scalar    = (dec_mode == ENC_UTF32LE) ? {b, nx_gather}
                                                              : {nx_gather, b};
                        scalar_go = 1'b1;
                        nx_gather = '0;
                        nx_phase  = 2'd0;
                    end
                end
                default:
                begin
                    bundle.item[cnt[1:0]] = make_item({8'd0, b}, KIND_RAW, dec_mode);
                    cnt = cnt + 3'd1;
                end
            endcase
        end

        // utf-16 unit with surrogate pairing
        is_hi = unit16[15:10] == HI_SURR_PREFIX;
        is_lo = unit16[15:10] == LO_SURR_PREFIX;
        if (unit_go)
        begin
            if (nx_held)
            begin
                if (is_lo)
                begin
                    bundle.item[cnt[1:0]] = make_item({HI_SURR_PREFIX, nx_surr},
                                                      KIND_UNIT, dec_mode);
                    cnt = cnt + 3'd1;
                    bundle.item[cnt[1:0]] = make_item(unit16, KIND_UNIT, dec_mode);
                    cnt = cnt + 3'd1;
                    pair_done = 1'b1;
                end
                else
                begin
                    bundle.item[cnt[1:0]] = make_item(REPLACEMENT, KIND_UNIT, dec_mode);
                    cnt = cnt + 3'd1;
                end
                nx_held = 1'b0;
                nx_surr = '0;
            end
            if (!pair_done)
            begin
                if (is_hi)
                begin
                    nx_surr = unit16[9:0];
                    nx_held = 1'b1;
                end
                else if (is_lo)
                begin
                    bundle.item[cnt[1:0]] = make_item(REPLACEMENT, KIND_UNIT, dec_mode);
                    cnt = cnt + 3'd1;
                end
                else
                begin
                    bundle.item[cnt[1:0]] = make_item(unit16, KIND_UNIT, dec_mode);
                    cnt = cnt + 3'd1;
                end
            end
        end

        // utf-32 scalar, split above the basic plane
        scalar_bad = scalar > SCALAR_MAX || (scalar >= SURR_MIN && scalar <= SURR_MAX);
        scalar_off = scalar[20:0] - PLANE1_BASE;
        if (scalar_go)
        begin
            if (scalar_bad)
            begin
                bundle.item[cnt[1:0]] = make_item(REPLACEMENT, KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
            end
            else if (scalar[31:16] == 16'd0)
            begin
                bundle.item[cnt[1:0]] = make_item(scalar[15:0], KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
            end
            else
            begin
                bundle.item[cnt[1:0]] = make_item({HI_SURR_PREFIX, scalar_off[19:10]},
                                                  KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
                bundle.item[cnt[1:0]] = make_item({LO_SURR_PREFIX, scalar_off[9:0]},
                                                  KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
            end
        end

        if (fin)
        begin
            if (nx_held)
            begin
                bundle.item[cnt[1:0]] = make_item(REPLACEMENT, KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
            end
            if (nx_phase != 2'd0 && dec_mode != ENC_UTF8)
            begin
                bundle.item[cnt[1:0]] = make_item(REPLACEMENT, KIND_UNIT, dec_mode);
                cnt = cnt + 3'd1;
            end
            if (cnt == 3'd0)
            begin
                bundle.item[cnt[1:0]] = make_item(16'd0, KIND_END, dec_mode);
                cnt = cnt + 3'd1;
            end
            bundle.item[cnt[1:0] - 2'd1].last_result = 1'b1;
        end
        bundle.count = cnt;
    end

    always_comb
    begin
        sniff_next       = sniff_reg;
        sniff_count_next = sniff_count_reg;
        mode_next        = mode_reg;
        gather_next      = gather_reg;
        phase_next       = phase_reg;
        surr_next        = surr_reg;
        held_next        = held_reg;
        if (fire)
        begin
            if (fin)
            begin
                sniff_next       = '0;
                sniff_count_next = 2'd0;
                mode_next        = ENC_UNDECIDED;
                gather_next      = '0;
                phase_next       = 2'd0;
                surr_next        = '0;
                held_next        = 1'b0;
            end
            else
            begin
                mode_next   = dec_mode;
                gather_next = nx_gather;
                phase_next  = nx_phase;
                surr_next   = nx_surr;
                held_next   = nx_held;
                if (keep)
                begin
                    if (sniff_count_reg != 2'd3)
                        sniff_next[sniff_count_reg] = b;
                    sniff_count_next = sniff_count_reg + 2'd1;
                end
                else
                begin
                    sniff_next       = '0;
                    sniff_count_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sniff_reg       <= '0;
            sniff_count_reg <= 2'd0;
            mode_reg        <= ENC_UNDECIDED;
            gather_reg      <= '0;
            phase_reg       <= 2'd0;
            surr_reg        <= '0;
            held_reg        <= 1'b0;
        end
        else
        begin
            sniff_reg       <= sniff_next;
            sniff_count_reg <= sniff_count_next;
            mode_reg        <= mode_next;
            gather_reg      <= gather_next;
            phase_reg       <= phase_next;
            surr_reg        <= surr_next;
            held_reg        <= held_next;
        end
    end

endmodule

// ===== rtl/bsu_out_queue.sv =====
// ----------------------------------------------------------------------------
// bsu_out_queue
// Result queue: takes up to four results in one cycle, hands out one per
// cycle on the valid/stall channel while stall is low.
// ----------------------------------------------------------------------------
module bsu_out_queue
    import bsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  res_bundle_t bundle,
    output logic        room,
    output logic        valid,
    input  logic        stall,
    output out_item_t   item
);

    localparam logic [QPTR_W:0] ROOM_LIMIT = (QPTR_W+1)'(QUEUE_DEPTH - MAX_RESULTS);

    out_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic [QPTR_W:0]   push_n;
    logic              pop;

    always_comb
    begin
        valid       = fill_reg != '0;
        item        = mem_reg[rd_ptr_reg];
        room        = fill_reg <= ROOM_LIMIT;
        pop         = valid && !stall;
        push_n      = push ? (QPTR_W+1)'(bundle.count) : '0;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + (pop ? QPTR_W'(1) : '0);
        fill_next   = fill_reg + push_n - (pop ? (QPTR_W+1)'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if (3'(k) < bundle.count)
                    mem_reg[wr_ptr_reg + QPTR_W'(k)] <= bundle.item[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/bom_sniff_utf16_utf32_to_utf16_top.sv =====
// ----------------------------------------------------------------------------
// bom_sniff_utf16_utf32_to_utf16_top
// Byte order mark sniffing transcoder: UTF-16/UTF-32 bytes in, UTF-16 code
// units (or raw UTF-8 bytes) out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while byte_stall is low. A byte lands in an input
// register, is decoded from there by a single pass of logic, and its results
// (zero to four) are written at once into an eight-entry result queue, which
// hands out one result per cycle while unit_stall is low. The input register
// holds (byte_stall high) only while the queue has fewer than four free
// entries, so a stream that causes at most one result per byte runs at one
// byte per cycle while the receiver does not stall; a burst of results from
// one byte is handed out one result at a time. The first bytes of each stream
// are held back while they could still be a byte order mark (up to three
// bytes), then released in the cycle the encoding is settled.
module bom_sniff_utf16_utf32_to_utf16_top
    import bsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // byte channel
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    // result channel
    output logic      unit_valid,
    input  logic      unit_stall,
    output out_item_t unit_item
);

    logic        item_valid_reg, item_valid_next;
    in_item_t    item_reg;
    logic        take;
    logic        fire;
    logic        room;
    res_bundle_t bundle;

    // input register advances when its byte is decoded or it is empty
    always_comb
    begin
        fire            = item_valid_reg && room;
        byte_stall      = item_valid_reg && !room;
        take            = byte_valid && !byte_stall;
        item_valid_next = take || (item_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= byte_item;
    end

    // mark sniffing, decoding and end-of-stream handling
    bsu_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .bundle (bundle)
    );

    // result queue, one transaction out per cycle while unit_stall is low
    bsu_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fire),
        .bundle (bundle),
        .room   (room),
        .valid  (unit_valid),
        .stall  (unit_stall),
        .item   (unit_item)
    );

    // a final byte always yields at least one result, never more than four
    a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.end_of_stream |-> bundle.count != 3'd0)
        else $error("final byte produced no result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> bundle.count <= 3'(MAX_RESULTS))
        else $error("too many results for one byte");

    // an end marker is always the last result of its stream
    a_end_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_item.result_kind == KIND_END |-> unit_item.last_result)
        else $error("end marker without last flag");

    // raw bytes only come out of a stream taken as utf-8
    a_raw_is_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_item.result_kind == KIND_RAW
            |-> unit_item.detected_encoding == ENC_UTF8)
        else $error("raw byte outside utf-8 stream");

endmodule

// ===== tb/sv/bom_sniff_utf16_utf32_to_utf16_top_tb.sv =====
// ----------------------------------------------------------------------------
// bom_sniff_utf16_utf32_to_utf16_top_tb
// Self-checking bench for the mark sniffing UTF-16/UTF-32 to UTF-16
// transcoder. Byte streams enter on the byte channel, and every result is
// compared in order, field by field, against a transcoder kept in the bench.
// ----------------------------------------------------------------------------
module bom_sniff_utf16_utf32_to_utf16_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsu_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BYTES = 150;
    localparam int MAX_GAP      = 15;
    localparam int HOLD_CYCLES  = 240;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 50;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;

    // byte order marks, left aligned, unused bytes zero
    localparam logic [0:3][7:0] MARK_UTF8    = {8'hEF, 8'hBB, 8'hBF, 8'h00};
    localparam logic [0:3][7:0] MARK_UTF32LE = {8'hFF, 8'hFE, 8'h00, 8'h00};
    localparam logic [0:3][7:0] MARK_UTF32BE = {8'h00, 8'h00, 8'hFE, 8'hFF};
    localparam logic [0:3][7:0] MARK_UTF16LE = {8'hFF, 8'hFE, 8'h00, 8'h00};
    localparam logic [0:3][7:0] MARK_UTF16BE = {8'hFE, 8'hFF, 8'h00, 8'h00};

    // shapes of the random streams
    typedef enum int {
        FORM_PLAIN       = 0,
        FORM_UTF8_MARK   = 1,
        FORM_U16LE       = 2,
        FORM_U16BE       = 3,
        FORM_U32LE       = 4,
        FORM_U32BE       = 5,
        FORM_BROKEN_MARK = 6,
        FORM_MARK_NOISE  = 7,
        FORM_MARK_JUNK   = 8
    } stream_form_t;

    // dut ports
    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      unit_valid;
    logic      unit_stall;
    out_item_t unit_item;

    // bench bookkeeping
    int cycle_count   = 0;
    int err_count     = 0;
    int bytes_sent    = 0;
    int streams_sent  = 0;
    int units_seen    = 0;
    int raw_seen      = 0;
    int ends_seen     = 0;
    int input_stalls  = 0;
    int tx_max_gap    = MAX_GAP;
    int rx_max_wait   = MAX_GAP;
    int rx_wait       = 0;
    int hold_left     = 0;

    // results still owed by the dut, oldest first
    out_item_t pending_units[$];

    // bench-side transcoder state
    logic [7:0]  sniff_buf [3];
    int          sniff_len;
    enc_t        enc_mode;
    logic [23:0] gather;
    logic [1:0]  phase;
    logic [9:0]  hi_surr;
    bit          hi_held;

    // results of the byte being predicted
    out_item_t   burst [MAX_RESULTS];
    int          burst_n;

    bom_sniff_utf16_utf32_to_utf16_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // transcoder prediction
    // ------------------------------------------------------------------

    function automatic void clear_decoder();
        sniff_buf[0] = '0;
        sniff_buf[1] = '0;
        sniff_buf[2] = '0;
        sniff_len    = 0;
        enc_mode     = ENC_UNDECIDED;
        gather       = '0;
        phase        = '0;
        hi_surr      = '0;
        hi_held      = 1'b0;
    endfunction

    function automatic void add_result(logic [15:0] unit, kind_t kind);
        if (burst_n < MAX_RESULTS) begin
            burst[burst_n].code_unit         = unit;
            burst[burst_n].result_kind       = kind;
            burst[burst_n].detected_encoding = enc_mode;
            burst[burst_n].last_result       = 1'b0;
            burst_n++;
        end
    endfunction

    // 0 mismatch, 1 prefix of the mark seen so far, 2 whole mark present
    function automatic int mark_match(logic [0:3][7:0] seen, int n,
                                      logic [0:3][7:0] mark, int len);
        int lim;
        int i;
        lim = (n < len) ? n : len;
        for (i = 0; i < lim; i++)
            if (seen[i] != mark[i])
                return 0;
        return (n >= len) ? 2 : 1;
    endfunction

    // longer marks win; a short UTF-16 mark only settles once nothing longer
    // can still match, or the stream ends
    function automatic enc_t sniff_mark(logic [0:3][7:0] seen, int n, bit fin,
                                        output int skip);
        int m8, m32le, m32be, m16le, m16be;
        m8    = mark_match(seen, n, MARK_UTF8, 3);
        m32le = mark_match(seen, n, MARK_UTF32LE, 4);
        m32be = mark_match(seen, n, MARK_UTF32BE, 4);
        m16le = mark_match(seen, n, MARK_UTF16LE, 2);
        m16be = mark_match(seen, n, MARK_UTF16BE, 2);
        skip = 0;
        if (m8 == 2) begin
            skip = 3;
            return ENC_UTF8;
        end
        if (m32le == 2) begin
            skip = 4;
            return ENC_UTF32LE;
        end
        if (m32be == 2) begin
            skip = 4;
            return ENC_UTF32BE;
        end
        if (!fin && (m8 == 1 || m32le == 1 || m32be == 1 || m16le == 1 || m16be == 1))
            return ENC_UNDECIDED;
        if (m16le == 2) begin
            skip = 2;
            return ENC_UTF16LE;
        end
        if (m16be == 2) begin
            skip = 2;
            return ENC_UTF16BE;
        end
        return ENC_UTF8;
    endfunction

    function automatic void put_unit16(logic [15:0] u);
        bit is_low;
        is_low = (u >= 16'hDC00 && u <= 16'hDFFF);
        if (hi_held) begin
            if (is_low) begin
                add_result({6'b110110, hi_surr}, KIND_UNIT);
                add_result(u, KIND_UNIT);
                hi_held = 1'b0;
                hi_surr = '0;
                return;
            end
            // high surrogate left unpaired
            add_result(REPL_UNIT, KIND_UNIT);
            hi_held = 1'b0;
            hi_surr = '0;
        end
        if (u >= 16'hD800 && u <= 16'hDBFF) begin
            hi_surr = u[9:0];
            hi_held = 1'b1;
        end else if (is_low) begin
            add_result(REPL_UNIT, KIND_UNIT);
        end else begin
            add_result(u, KIND_UNIT);
        end
    endfunction

    function automatic void put_scalar(logic [31:0] s);
        logic [31:0] v;
        logic [31:0] t;
        v = s;
        if (v > 32'h0010_FFFF || (v >= 32'h0000_D800 && v <= 32'h0000_DFFF))
            v = 32'h0000_FFFD;
        if (v <= 32'h0000_FFFF) begin
            add_result(v[15:0], KIND_UNIT);
        end else begin
            t = v - 32'h0001_0000;
            add_result({6'b110110, t[19:10]}, KIND_UNIT);
            add_result({6'b110111, t[9:0]}, KIND_UNIT);
        end
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        logic [15:0] u;
        logic [31:0] s;
        case (enc_mode)
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (phase == 2'd0) begin
                    gather = {16'h0000, b};
                    phase  = 2'd1;
                end else begin
                    u = (enc_mode == ENC_UTF16LE) ? {b, gather[7:0]} : {gather[7:0], b};
                    gather = '0;
                    phase  = 2'd0;
                    put_unit16(u);
                end
            end
            ENC_UTF32LE, ENC_UTF32BE: begin
                if (phase < 2'd3) begin
                    if (enc_mode == ENC_UTF32LE)
                        gather[8*phase +: 8] = b;
                    else
                        gather = {gather[15:0], b};
                    phase = phase + 2'd1;
                end else begin
                    s = (enc_mode == ENC_UTF32LE) ? {b, gather} : {gather, b};
                    gather = '0;
                    phase  = 2'd0;
                    put_scalar(s);
                end
            end
            default: add_result({8'h00, b}, KIND_RAW);
        endcase
    endfunction

    // works out the results of one accepted byte and queues them
    function automatic void predict_transcode(logic [7:0] b, bit fin);
        logic [0:3][7:0] seen;
        int   n;
        int   skip;
        int   i;
        enc_t found;
        burst_n = 0;
        if (enc_mode == ENC_UNDECIDED) begin
            seen = '0;
            for (i = 0; i < sniff_len; i++)
                seen[i] = sniff_buf[i];
            seen[sniff_len] = b;
            n = sniff_len + 1;
            found = sniff_mark(seen, n, fin, skip);
            if (found == ENC_UNDECIDED) begin
                if (sniff_len < 3)
                    sniff_buf[sniff_len] = b;
                sniff_len++;
            end else begin
                enc_mode  = found;
                sniff_len = 0;
                sniff_buf[0] = '0;
                sniff_buf[1] = '0;
                sniff_buf[2] = '0;
                for (i = skip; i < n; i++)
                    feed_byte(seen[i]);
            end
        end else begin
            feed_byte(b);
        end
        if (fin) begin
            // held high surrogate first, then any partial unit
            if (hi_held)
                add_result(REPL_UNIT, KIND_UNIT);
            if (phase != 2'd0 && enc_mode != ENC_UTF8)
                add_result(REPL_UNIT, KIND_UNIT);
            if (burst_n == 0)
                add_result(16'h0000, KIND_END);
            burst[burst_n-1].last_result = 1'b1;
            clear_decoder();
        end
        for (i = 0; i < burst_n; i++)
            pending_units = {pending_units, burst[i]};
    endfunction

    // ------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------

    function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q = {q, b};
    endfunction

    function automatic void push_mark(ref logic [7:0] q[$], input logic [0:3][7:0] mark,
                                      input int len);
        int i;
        for (i = 0; i < len; i++)
            append_byte(q, mark[i]);
    endfunction

    function automatic void push_u16(ref logic [7:0] q[$], input logic [15:0] u,
                                     input bit le);
        if (le) begin
            append_byte(q, u[7:0]);
            append_byte(q, u[15:8]);
        end else begin
            append_byte(q, u[15:8]);
            append_byte(q, u[7:0]);
        end
    endfunction

    function automatic void push_u32(ref logic [7:0] q[$], input logic [31:0] s,
                                     input bit le);
        int i;
        for (i = 0; i < 4; i++)
            append_byte(q, le ? s[8*i +: 8] : s[8*(3-i) +: 8]);
    endfunction

    // one UTF-16 item: plain unit, proper pair, or a broken surrogate
    function automatic void push_u16_item(ref logic [7:0] q[$], input bit le);
        logic [15:0] hi;
        logic [15:0] lo;
        hi = 16'hD800 | 16'($urandom_range(0, 1023));
        lo = 16'hDC00 | 16'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0, 1, 2: push_u16(q, 16'($urandom_range(0, 16'hD7FF)), le);
            3, 4: begin
                push_u16(q, hi, le);
                push_u16(q, lo, le);
            end
            5: push_u16(q, hi, le);
            6: push_u16(q, lo, le);
            7: push_u16(q, 16'($urandom_range(16'hE000, 16'hFFFF)), le);
            8: push_u16(q, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, le);
            default: push_u16(q, 16'($urandom), le);
        endcase
    endfunction

    // one UTF-32 scalar: BMP, supplementary, surrogate, out of range, edges
    function automatic void push_u32_item(ref logic [7:0] q[$], input bit le);
        logic [31:0] s;
        case ($urandom_range(0, 8))
            0, 1: s = $urandom_range(0, 32'h0000_D7FF);
            2:    s = $urandom_range(32'h0000_E000, 32'h0000_FFFF);
            3, 4: s = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
            5:    s = $urandom_range(32'h0000_D800, 32'h0000_DFFF);
            6:    s = $urandom_range(32'h0011_0000, 32'hFFFF_FFFF);
            7: begin
                case ($urandom_range(0, 5))
                    0:       s = 32'h0000_0000;
                    1:       s = 32'h0000_FFFF;
                    2:       s = 32'h0001_0000;
                    3:       s = 32'h0010_FFFF;
                    4:       s = 32'h0011_0000;
                    default: s = 32'hFFFF_FFFF;
                endcase
            end
            default: s = $urandom;
        endcase
        push_u32(q, s, le);
    endfunction

    function automatic void push_any_mark(ref logic [7:0] q[$], input bit partial);
        logic [0:3][7:0] mark;
        int len;
        case ($urandom_range(0, 4))
            0: begin mark = MARK_UTF8;    len = 3; end
            1: begin mark = MARK_UTF32LE; len = 4; end
            2: begin mark = MARK_UTF32BE; len = 4; end
            3: begin mark = MARK_UTF16LE; len = 2; end
            default: begin mark = MARK_UTF16BE; len = 2; end
        endcase
        push_mark(q, mark, partial ? $urandom_range(1, len - 1) : len);
    endfunction

    function automatic void make_stream(ref logic [7:0] q[$]);
        stream_form_t form;
        int  count;
        int  i;
        bit  le;
        q.delete();
        form  = stream_form_t'($urandom_range(0, 8));
        count = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
        case (form)
            FORM_PLAIN:
                for (i = 0; i < count; i++)
                    append_byte(q, 8'($urandom));
            FORM_UTF8_MARK: begin
                push_mark(q, MARK_UTF8, 3);
                for (i = 0; i < count; i++)
                    append_byte(q, 8'($urandom));
            end
            FORM_U16LE, FORM_U16BE: begin
                le = (form == FORM_U16LE);
                push_mark(q, le ? MARK_UTF16LE : MARK_UTF16BE, 2);
                for (i = 0; i < count; i++)
                    push_u16_item(q, le);
                if ($urandom_range(0, 4) == 0)
                    append_byte(q, 8'($urandom));
            end
            FORM_U32LE, FORM_U32BE: begin
                le = (form == FORM_U32LE);
                push_mark(q, le ? MARK_UTF32LE : MARK_UTF32BE, 4);
                for (i = 0; i < count; i++)
                    push_u32_item(q, le);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        append_byte(q, 8'($urandom));
            end
            FORM_BROKEN_MARK: begin
                push_any_mark(q, 1'b1);
                for (i = 0; i < count; i++)
                    append_byte(q, 8'($urandom));
            end
            FORM_MARK_NOISE:
                for (i = 0; i < 2 * count; i++) begin
                    case ($urandom_range(0, 6))
                        0:       append_byte(q, 8'h00);
                        1:       append_byte(q, 8'hFE);
                        2:       append_byte(q, 8'hFF);
                        3:       append_byte(q, 8'hEF);
                        4:       append_byte(q, 8'hBB);
                        5:       append_byte(q, 8'hBF);
                        default: append_byte(q, 8'($urandom));
                    endcase
                end
            default: begin
                push_any_mark(q, 1'b0);
                for (i = 0; i < count; i++)
                    append_byte(q, 8'($urandom));
            end
        endcase
        if (q.size() == 0)
            append_byte(q, 8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // byte channel driver
    // ------------------------------------------------------------------

    // every call starts at a rising edge; valid stays up across back to back
    // transactions and only drops for a gap
    task automatic send_byte(logic [7:0] b, bit fin);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= {b, fin};
        do
            @(posedge clk);
        while (byte_stall);
        predict_transcode(b, fin);
        bytes_sent++;
    endtask

    task automatic send_stream(input logic [7:0] stream_bytes[$]);
        int i;
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        streams_sent++;
    endtask

    // byte i of the stream sits at v[8*(n-1-i) +: 8]
    task automatic send_packed(logic [127:0] v, int n);
        logic [7:0] q[$];
        int i;
        for (i = 0; i < n; i++)
            append_byte(q, v[8*(n-1-i) +: 8]);
        send_stream(q);
    endtask

    // sender goes quiet until every owed result has come out
    task automatic drain_results();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_units.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // result channel: stall pattern and checking
    // ------------------------------------------------------------------

    // long hold-off counted down on its own
    always @(posedge clk)
        if (hold_left != 0)
            hold_left <= hold_left - 1;

    // fresh wait drawn after every result transaction
    always @(posedge clk) begin
        if (unit_valid && !unit_stall)
            rx_wait = $urandom_range(0, rx_max_wait);
        else if (rx_wait != 0)
            rx_wait = rx_wait - 1;
        unit_stall <= (hold_left != 0) || (rx_wait != 0);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        err_count++;
    endtask

    always @(posedge clk) begin : check_units
        out_item_t want;
        if (rst_n && unit_valid && !unit_stall) begin
            if (pending_units.size() == 0) begin
                report_mismatch("result with nothing owed, code_unit",
                                32'(unit_item.code_unit), 32'd0);
            end else begin
                want = pending_units.pop_front();
                if (unit_item.code_unit !== want.code_unit)
                    report_mismatch("code_unit", 32'(unit_item.code_unit),
                                    32'(want.code_unit));
                if (unit_item.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 32'(unit_item.result_kind),
                                    32'(want.result_kind));
                if (unit_item.detected_encoding !== want.detected_encoding)
                    report_mismatch("detected_encoding", 32'(unit_item.detected_encoding),
                                    32'(want.detected_encoding));
                if (unit_item.last_result !== want.last_result)
                    report_mismatch("last_result", 32'(unit_item.last_result),
                                    32'(want.last_result));
                case (want.result_kind)
                    KIND_UNIT: units_seen++;
                    KIND_RAW:  raw_seen++;
                    default:   ends_seen++;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (byte_valid && byte_stall)
            input_stalls <= input_stalls + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout at cycle %0d with %0d results still owed",
                 cycle_count, pending_units.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // marks that settle at end of stream, and a cut-off mark
    task automatic test_mark_sniffing();
        // UTF-8 mark alone: dropped, so only the end marker comes out
        send_packed(128'({8'hEF, 8'hBB, 8'hBF}), 3);
        // first two bytes of the UTF-8 mark: passed out raw
        send_packed(128'({8'hEF, 8'hBB}), 2);
        // FF FE 00 at end: UTF-16LE with one odd trailing byte
        send_packed(128'({8'hFF, 8'hFE, 8'h00}), 3);
    endtask

    // out of range scalar and a partial trailing scalar
    task automatic test_utf32_scalars();
        send_packed(128'({8'h00, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h11, 8'h00, 8'h00,
                          8'hFF}), 9);
    endtask

    task automatic test_utf16_surrogates();
        // FF FE 00 then nonzero: the 00 opens the first unit; high surrogate
        // at end ahead of the odd byte
        send_packed(128'({8'hFF, 8'hFE, 8'h00, 8'h41, 8'h00, 8'hD8, 8'h7F}), 7);
        // unpaired high surrogate, then a lone low one
        send_packed(128'({8'hFE, 8'hFF, 8'hD8, 8'h00, 8'h00, 8'h41, 8'hDC, 8'h00}), 8);
    endtask

    // sender waits for every result of a stream before the next one
    task automatic test_sender_pause();
        logic [7:0] q[$];
        int i;
        tx_max_gap  = 0;
        rx_max_wait = MAX_GAP;
        for (i = 0; i < 3; i++) begin
            q.delete();
            push_mark(q, MARK_UTF16BE, 2);
            repeat (4) push_u16_item(q, 1'b0);
            send_stream(q);
            drain_results();
        end
    endtask

    // receiver holds off while a pair-heavy stream keeps coming, so the
    // result queue fills and the byte channel has to stall
    task automatic test_input_backpressure();
        logic [7:0] q[$];
        tx_max_gap  = 0;
        rx_max_wait = 0;
        push_mark(q, MARK_UTF32BE, 4);
        repeat (12) push_u32(q, $urandom_range(32'h0001_0000, 32'h0010_FFFF), 1'b0);
        hold_left <= HOLD_CYCLES;
        send_stream(q);
        drain_results();
    endtask

    task automatic test_random_streams();
        logic [7:0] q[$];
        int start;
        int n;
        start = bytes_sent;
        n     = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            // stretches with and without idling on either side
            case ($urandom_range(0, 3))
                0:       begin tx_max_gap = 0;       rx_max_wait = 0;       end
                1:       begin tx_max_gap = MAX_GAP; rx_max_wait = 0;       end
                2:       begin tx_max_gap = 0;       rx_max_wait = MAX_GAP; end
                default: begin tx_max_gap = MAX_GAP; rx_max_wait = MAX_GAP; end
            endcase
            make_stream(q);
            send_stream(q);
            n++;
            if (n % 6 == 0)
                drain_results();
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        unit_stall = 1'b0;
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mark_sniffing();
        test_utf32_scalars();
        test_utf16_surrogates();
        test_sender_pause();
        test_input_backpressure();
        test_random_streams();

        // all bytes in: wait out the owed results, then a quiet tail that
        // would catch any stray result
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d streams, %0d bytes in, %0d cycles, %0d cycles of input stall",
                 streams_sent, bytes_sent, cycle_count, input_stalls);
        $display("checked %0d UTF-16 units, %0d raw bytes, %0d end markers, %0d errors",
                 units_seen, raw_seen, ends_seen, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
